// ===== hw/rtl/ulbc_pkg.sv =====
// Shared types and constants for the serial-command LED blink controller.
// No dependencies; used by the controller, the checker and the testbench.
package ulbc_pkg;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  response;
      logic        led_level;
      logic [16:0] reload_value;
   } rsp_type;

   localparam logic       MODE_BYTE = 1'b0;
   localparam logic       MODE_TICK = 1'b1;

   localparam logic [1:0] RESP_NONE      = 2'd0;
   localparam logic [1:0] RESP_OK        = 2'd1;
   localparam logic [1:0] RESP_BAD_VALUE = 2'd2;
   localparam logic [1:0] RESP_CMD_ERROR = 2'd3;

   localparam logic [16:0] RELOAD_RESET = 17'd999;
   localparam logic [16:0] VALUE_CAP    = 17'd100000;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_M     = 8'h6D;
   localparam logic [7:0] CHAR_S     = 8'h73;

   // Text of the two fixed commands, first character in the top byte.
   localparam logic [8*8-1:0] TXT_START = "LedStart";
   localparam logic [7*8-1:0] TXT_STOP  = "LedStop";

endpackage

// ===== hw/rtl/ulbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ulbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/uart_command_led_blink_control.sv =====
// LED blink controller commanded by text lines from a serial receiver.
// Depends on ulbc_pkg and ulbc_ram.
//
// Each item is a received byte (mode 0) or one 10 kHz timer tick (mode 1), and each
// item gives exactly one result: a response code, the LED level and the current
// reload value. Bytes are written into a line store RAM of LINE_BYTES entries. A
// newline, or any byte arriving while LINE_BYTES-1 bytes are held (that byte is
// dropped), ends the line; the line is then parsed by walking the stored bytes one
// per cycle through the RAM read port. Commands: "LedStop" stops blinking and clears
// the LED, "LedStart" starts blinking, "Led<n>ms" (n 1..1000) or "Led<n>s" (n 1..10)
// sets the reload to n*10-1 or n*10000-1 ticks. Whitespace and a plus sign may lead
// the number; a minus sign, missing digits, a value out of range or any other bad
// text after "Led" answer "invalid value", and a line not starting with "Led"
// answers "command error". A line end holds the input stalled while each held byte
// and one terminating position are read through the RAM read port, the read
// pipeline drains and the result is committed. The result register lets the input
// be taken again in the cycle its result is read out.
module uart_command_led_blink_control
   import ulbc_pkg::*;
#(
   parameter int LINE_BYTES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(LINE_BYTES);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // number parser after the "Led" prefix
   typedef enum logic [3:0] {
      N_BLANK = 4'b0001,
      N_DIGIT = 4'b0010,
      N_SUFM  = 4'b0100,
      N_DONE  = 4'b1000
   } num_state_type;

   typedef enum logic [2:0] {
      NRES_BAD = 3'b001,
      NRES_MS  = 3'b010,
      NRES_S   = 3'b100
   } num_res_type;

   // control
   state_type     state_ff, state_in;
   logic [AW-1:0] len_ff, len_in;
   logic          running_ff, running_in;
   logic [16:0]   reload_ff, reload_in;
   logic [16:0]   count_ff, count_in;
   logic          led_ff, led_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          issue_ff, issue_in;
   logic          proc_valid_ff, proc_valid_in;

   // payload
   rsp_type       rsp_data_ff, rsp_data_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] proc_pos_ff, proc_pos_in;
   logic          zero_seen_ff, zero_seen_in;
   logic          prefix_bad_ff, prefix_bad_in;
   logic          stop_ok_ff, stop_ok_in;
   logic          start_ok_ff, start_ok_in;
   num_state_type nstate_ff, nstate_in;
   num_res_type   nres_ff, nres_in;
   logic          minus_ff, minus_in;
   logic          have_dig_ff, have_dig_in;
   logic [16:0]   val_ff, val_in;

   // RAM port
   logic          wr_en;
   logic [7:0]    rd_data;

   logic          can_take;
   logic          accept;
   logic          line_end;
   logic [7:0]    ch;
   logic          ch_blank;
   logic          ch_digit;
   logic          dig_phase;
   logic [20:0]   acc;
   logic [2:0]    k;
   logic          range_ms;
   logic          range_s;

   ulbc_ram #(
      .WIDTH (8),
      .DEPTH (LINE_BYTES)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff),
      .wr_data (req_data.rx_byte),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   // Output slot is free when empty or being read out this cycle.
   assign can_take  = !(rsp_valid_ff && rsp_stall);
   assign req_stall = (state_ff != ST_IDLE) || !can_take;
   assign accept    = req_valid && !req_stall;
   assign line_end  = (req_data.rx_byte == CHAR_LF) ||
                      (len_ff >= AW'(LINE_BYTES - 1));
   assign wr_en     = accept && (req_data.mode == MODE_BYTE) && !line_end;

   // Past the line length or the first zero byte, text reads as zero.
   assign ch       = (proc_pos_ff < len_ff && !zero_seen_ff) ? rd_data : CHAR_NUL;
   assign ch_blank = (ch == CHAR_SPACE) || (ch >= CHAR_TAB && ch <= CHAR_CR);
   assign ch_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   assign acc      = {4'd0, val_ff} * 21'd10 + {13'd0, ch - CHAR_ZERO};
   assign k        = proc_pos_ff[2:0];
   assign range_ms = (val_ff >= 17'd1) && (val_ff <= 17'd1000);
   assign range_s  = (val_ff >= 17'd1) && (val_ff <= 17'd10);

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      running_in    = running_ff;
      reload_in     = reload_ff;
      count_in      = count_ff;
      led_in        = led_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      issue_in      = issue_ff;
      proc_valid_in = 1'b0;
      pos_in        = pos_ff;
      proc_pos_in   = proc_pos_ff;
      zero_seen_in  = zero_seen_ff;
      prefix_bad_in = prefix_bad_ff;
      stop_ok_in    = stop_ok_ff;
      start_ok_in   = start_ok_ff;
      nstate_in     = nstate_ff;
      nres_in       = nres_ff;
      minus_in      = minus_ff;
      have_dig_in   = have_dig_ff;
      val_in        = val_ff;
      dig_phase     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.mode == MODE_TICK) begin
                  if (count_ff >= reload_ff) begin
                     count_in = '0;
                     if (running_ff) begin
                        led_in = !led_ff;
                     end
                  end else begin
                     count_in = count_ff + 17'd1;
                  end
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{RESP_NONE, led_in, reload_ff};
               end else if (line_end) begin
                  // start the walk over the stored line
                  state_in      = ST_WALK;
                  issue_in      = 1'b1;
                  pos_in        = '0;
                  zero_seen_in  = 1'b0;
                  prefix_bad_in = 1'b0;
                  stop_ok_in    = 1'b1;
                  start_ok_in   = 1'b1;
                  nstate_in     = N_BLANK;
                  nres_in       = NRES_BAD;
                  minus_in      = 1'b0;
                  have_dig_in   = 1'b0;
                  val_in        = '0;
               end else begin
                  len_in       = len_ff + AW'(1);
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{RESP_NONE, led_ff, reload_ff};
               end
            end
         end

         ST_WALK: begin
            // issue side: addresses 0..len, one per cycle
            if (issue_ff) begin
               proc_valid_in = 1'b1;
               proc_pos_in   = pos_ff;
               if (pos_ff == len_ff) begin
                  issue_in = 1'b0;
               end else begin
                  pos_in = pos_ff + AW'(1);
               end
            end

            // parse side: one character per cycle
            if (proc_valid_ff) begin
               if (ch == CHAR_NUL) begin
                  zero_seen_in = 1'b1;
               end
               if (proc_pos_ff < AW'(3) && ch != TXT_STOP[8*(6-k) +: 8]) begin
                  prefix_bad_in = 1'b1;
               end
               if (proc_pos_ff < AW'(7) && ch != TXT_STOP[8*(6-k) +: 8]) begin
                  stop_ok_in = 1'b0;
               end
               if (proc_pos_ff < AW'(8) && ch != TXT_START[8*(7-k) +: 8]) begin
                  start_ok_in = 1'b0;
               end

               if (proc_pos_ff >= AW'(3)) begin
                  case (nstate_ff)
                     N_BLANK: begin
                        if (ch_blank) begin
                           nstate_in = N_BLANK;
                        end else if (ch == CHAR_PLUS) begin
                           nstate_in = N_DIGIT;
                        end else if (ch == CHAR_MINUS) begin
                           minus_in  = 1'b1;
                           nstate_in = N_DIGIT;
                        end else begin
                           dig_phase = 1'b1;
                        end
                     end
                     N_DIGIT: begin
                        dig_phase = 1'b1;
                     end
                     N_SUFM: begin
                        nres_in   = (ch == CHAR_S && range_ms) ? NRES_MS : NRES_BAD;
                        nstate_in = N_DONE;
                     end
                     N_DONE: begin
                        nstate_in = N_DONE;
                     end
                     default: begin
                        nstate_in = N_DONE;
                     end
                  endcase

                  if (dig_phase) begin
                     if (ch_digit) begin
                        val_in      = (acc > {4'd0, VALUE_CAP}) ? VALUE_CAP : acc[16:0];
                        have_dig_in = 1'b1;
                        nstate_in   = N_DIGIT;
                     end else if (!have_dig_ff || minus_ff) begin
                        nres_in   = NRES_BAD;
                        nstate_in = N_DONE;
                     end else if (ch == CHAR_M) begin
                        nstate_in = N_SUFM;
                     end else if (ch == CHAR_S) begin
                        nres_in   = range_s ? NRES_S : NRES_BAD;
                        nstate_in = N_DONE;
                     end else begin
                        nres_in   = NRES_BAD;
                        nstate_in = N_DONE;
                     end
                  end
               end

               if (proc_pos_ff == len_ff) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            // commit the command; output slot is empty here
            state_in     = ST_IDLE;
            len_in       = '0;
            rsp_valid_in = 1'b1;
            if (prefix_bad_ff) begin
               rsp_data_in.response = RESP_CMD_ERROR;
            end else if (stop_ok_ff) begin
               running_in           = 1'b0;
               led_in               = 1'b0;
               rsp_data_in.response = RESP_OK;
            end else if (start_ok_ff) begin
               running_in           = 1'b1;
               rsp_data_in.response = RESP_OK;
            end else begin
               case (nres_ff)
                  NRES_MS: begin
                     reload_in = 17'({7'd0, val_ff[9:0]} * 17'd10) - 17'd1;
                     rsp_data_in.response = RESP_OK;
                  end
                  NRES_S: begin
                     reload_in = 17'({13'd0, val_ff[3:0]} * 17'd10000) - 17'd1;
                     rsp_data_in.response = RESP_OK;
                  end
                  default: begin
                     rsp_data_in.response = RESP_BAD_VALUE;
                  end
               endcase
            end
            rsp_data_in.led_level    = led_in;
            rsp_data_in.reload_value = reload_in;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= '0;
         running_ff    <= 1'b0;
         reload_ff     <= RELOAD_RESET;
         count_ff      <= '0;
         led_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         issue_ff      <= 1'b0;
         proc_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         running_ff    <= running_in;
         reload_ff     <= reload_in;
         count_ff      <= count_in;
         led_ff        <= led_in;
         rsp_valid_ff  <= rsp_valid_in;
         issue_ff      <= issue_in;
         proc_valid_ff <= proc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      pos_ff        <= pos_in;
      proc_pos_ff   <= proc_pos_in;
      zero_seen_ff  <= zero_seen_in;
      prefix_bad_ff <= prefix_bad_in;
      stop_ok_ff    <= stop_ok_in;
      start_ok_ff   <= start_ok_in;
      nstate_ff     <= nstate_in;
      nres_ff       <= nres_in;
      minus_ff      <= minus_in;
      have_dig_ff   <= have_dig_in;
      val_ff        <= val_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/ulbc_checker.sv =====
// Port-level checks for the LED blink controller, bound to the top level.
// Depends on ulbc_pkg and uart_command_led_blink_control.
module ulbc_checker
   import ulbc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // a tick item answers in the next cycle with no response code
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.mode == MODE_TICK
      |=> rsp_valid && rsp_data.response == RESP_NONE)
      else $error("tick item not answered next cycle");

   // a newline starts the parse, so input is held off next cycle
   a_newline_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.mode == MODE_BYTE &&
      req_data.rx_byte == CHAR_LF |=> req_stall && !rsp_valid)
      else $error("newline did not start a parse");

   // reload stays within the legal range
   a_reload_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.reload_value >= 17'd9 && rsp_data.reload_value <= 17'd99999)
      else $error("reload value out of range");

endmodule

bind uart_command_led_blink_control ulbc_checker u_ulbc_checker (.*);

// ===== verif/tb_top.sv =====
// Testbench for uart_command_led_blink_control: byte and tick items in, one result per item.
// Depends on ulbc_pkg for the item types and codes.
// An in-bench predictor of the command parser and blink timer checks every result.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ulbc_pkg::*;

   localparam int LINE_BYTES   = 64;
   localparam int TOTAL_ITEMS  = 1250;
   // Worst correct gap between accepts is the parse after a line end plus
   // a few receiver stalls; this is many times that.
   localparam int STUCK_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = LINE_BYTES + 8;
   localparam int PRINT_CAP    = 40;

   // Vertical tab and form feed also count as blanks before the number.
   localparam logic [7:0] CHAR_VT = 8'h0B;
   localparam logic [7:0] CHAR_FF = 8'h0C;
   localparam logic [7:0] BLANKS [5] = '{CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF, CHAR_CR};

   // ------------------------------------------------------------------
   // Predictor and result store.
   // Keeps its own copy of the line store, the blink flag, the timer
   // reload and count and the LED level, and queues one expected result
   // per accepted item.
   // ------------------------------------------------------------------
   class led_cmd_scoreboard;
      logic [7:0]  line_bytes [LINE_BYTES];
      int          line_len;
      int          text_len;
      bit          running;
      bit          led;
      logic [16:0] reload;
      logic [16:0] count;
      rsp_type     expected_q [$];
      int          errors;
      int          n_items, n_ticks, n_lines, n_ok, n_bad, n_err, n_toggles;

      function new();
         reload = RELOAD_RESET;
         count  = '0;
      endfunction

      // Text ends at the first NUL or at the held length.
      function logic [7:0] char_at(int i);
         return (i < text_len) ? line_bytes[i] : CHAR_NUL;
      endfunction

      function bit has_prefix(string p);
         foreach (p[k])
            if (char_at(k) != p[k]) return 1'b0;
         return 1'b1;
      endfunction

      function logic [1:0] parse_line();
         int          pos;
         int          i;
         int unsigned value;
         bit          minus;
         logic [7:0]  c;
         value    = 0;
         minus    = 1'b0;
         text_len = 0;
         while (text_len < line_len && line_bytes[text_len] != CHAR_NUL) text_len++;

         if (!has_prefix("Led")) return RESP_CMD_ERROR;
         if (has_prefix("LedStop")) begin
            running = 1'b0;
            led     = 1'b0;
            return RESP_OK;
         end
         if (has_prefix("LedStart")) begin
            running = 1'b1;
            return RESP_OK;
         end

         pos = 3;
         c   = char_at(pos);
         while (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
            pos++;
            c = char_at(pos);
         end
         if (c == CHAR_PLUS) begin
            pos++;
         end else if (c == CHAR_MINUS) begin
            minus = 1'b1;
            pos++;
         end
         i = pos;
         c = char_at(i);
         while (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            value = value * 10 + (c - CHAR_ZERO);
            if (value > VALUE_CAP) value = VALUE_CAP;   // saturate huge numbers
            i++;
            c = char_at(i);
         end
         if (i == pos || minus) return RESP_BAD_VALUE;

         if (c == CHAR_M && char_at(i + 1) == CHAR_S && value >= 1 && value <= 1000) begin
            reload = 17'(value * 10 - 1);
            return RESP_OK;
         end
         if (c == CHAR_S && value >= 1 && value <= 10) begin
            reload = 17'(value * 10000 - 1);
            return RESP_OK;
         end
         return RESP_BAD_VALUE;
      endfunction

      // Called for every accepted input item.
      function void note_item(req_type item);
         rsp_type    exp;
         logic [1:0] code;
         code = RESP_NONE;
         n_items++;
         if (item.mode == MODE_TICK) begin
            n_ticks++;
            // A count at or above the reload (e.g. after a shorter reload was
            // written) wraps right away.
            if (count >= reload) begin
               count = '0;
               if (running) begin
                  led = !led;
                  n_toggles++;
               end
            end else begin
               count = count + 1'b1;
            end
         end else if (item.rx_byte == CHAR_LF || line_len >= LINE_BYTES - 1) begin
            // Newline, or a byte arriving on a full store (dropped): line ends.
            code = parse_line();
            line_len = 0;
            n_lines++;
            case (code)
               RESP_OK:        n_ok++;
               RESP_BAD_VALUE: n_bad++;
               default:        n_err++;
            endcase
         end else begin
            line_bytes[line_len] = item.rx_byte;
            line_len++;
         end
         exp.response     = code;
         exp.led_level    = led;
         exp.reload_value = reload;
         expected_q.push_back(exp);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= PRINT_CAP) $display("[%0t] MISMATCH %s", $time, msg);
      endtask

      // Called for every accepted result item.
      task check_result(rsp_type got);
         rsp_type exp;
         if (expected_q.size() == 0) begin
            report($sformatf("result with nothing pending: resp %0d led %0b reload %0d",
                             got.response, got.led_level, got.reload_value));
            return;
         end
         exp = expected_q.pop_front();
         if (got.response !== exp.response)
            report($sformatf("response %0d, expected %0d", got.response, exp.response));
         if (got.led_level !== exp.led_level)
            report($sformatf("led_level %0b, expected %0b", got.led_level, exp.led_level));
         if (got.reload_value !== exp.reload_value)
            report($sformatf("reload_value %0d, expected %0d",
                             got.reload_value, exp.reload_value));
      endtask
   endclass

   // ------------------------------------------------------------------
   // Clock, reset, DUT
   // ------------------------------------------------------------------
   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   led_cmd_scoreboard sb = new();

   bit         no_idle    = 1'b0;   // both sides stop idling while set
   int         items_sent = 0;
   int         stuck      = 0;
   logic [7:0] line_buf [$];        // bytes of the line being built

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   uart_command_led_blink_control #(
      .LINE_BYTES(LINE_BYTES)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Receiver: stalls at random, about 11% of the time, never during the quiet stretch.
   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 11);
   end

   // Monitor. Samples pre-edge values; a result is checked before the input
   // accepted at the same edge is noted, since it belongs to an older item.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (req_valid && !req_stall) sb.note_item(req_data);
      end
   end

   // Watchdog: cycles in a row with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck <= 0;
      end else if (stuck == STUCK_LIMIT) begin
         $display("[%0t] no item moved for %0d cycles", $time, STUCK_LIMIT);
         $display("tb_top NOT OK");
         $finish;
      end else begin
         stuck <= stuck + 1;
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Optional idle cycles, then hold the item until the DUT takes it.
   task automatic send_item(input req_type item);
      while (!no_idle && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Ticks carry a random don't-care byte so every rx_byte bit moves here too.
   task automatic send_ticks(input int n);
      req_type item;
      repeat (n) begin
         item.mode    = MODE_TICK;
         item.rx_byte = 8'($urandom_range(255));
         send_item(item);
      end
   endtask

   task automatic add_byte(input logic [7:0] b);
      line_buf.push_back(b);
   endtask

   task automatic add_text(input string s);
      foreach (s[k]) line_buf.push_back(s[k]);
   endtask

   task automatic send_buf();
      req_type item;
      foreach (line_buf[k]) begin
         item.mode    = MODE_BYTE;
         item.rx_byte = line_buf[k];
         send_item(item);
      end
      line_buf.delete();
   endtask

   task automatic send_line(input string s);
      add_text(s);
      add_byte(CHAR_LF);
      send_buf();
   endtask

   // Mostly well-formed commands with random spacing, sign, value and
   // suffix, plus a share of bad values, NULs, junk tails and overfull lines.
   task automatic random_command();
      int    pick;
      string digits;
      string suffix;
      pick = $urandom_range(99);
      if (pick < 10) begin
         add_text("LedStart");
      end else if (pick < 16) begin
         add_text("LedStop");
      end else begin
         add_text("Led");
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) add_byte(BLANKS[$urandom_range(4)]);
         case ($urandom_range(19))
            0, 1, 2: add_byte(CHAR_PLUS);
            3:       add_byte(CHAR_MINUS);
            default: ;
         endcase
         suffix = "ms";
         pick = $urandom_range(99);
         // Short periods dominate so the LED actually toggles between commands.
         if (pick < 50) begin
            digits = $sformatf("%0d", $urandom_range(1, 20));
         end else if (pick < 65) begin
            digits = $sformatf("%0d", $urandom_range(1, 1000));
         end else if (pick < 73) begin
            digits = $sformatf("%0d", $urandom_range(1, 10));
            suffix = "s";
         end else if (pick < 80) begin
            digits = "";                                       // no digits
         end else if (pick < 86) begin
            digits = $sformatf("%0d", $urandom_range(1001, 99999));
         end else if (pick < 91) begin
            digits = $sformatf("%0d", $urandom_range(1) ? 0 : $urandom_range(11, 999));
            suffix = "s";
         end else if (pick < 95) begin
            digits = $sformatf("%0d%0d", $urandom(), $urandom());  // saturates
         end else begin
            digits = $sformatf("%0d", $urandom_range(1, 50));
            suffix = $urandom_range(1) ? "m" : "x";
         end
         if (digits != "" && $urandom_range(7) == 0) digits = {"00", digits};
         add_text(digits);
         add_text(suffix);
      end
      if ($urandom_range(4) == 0)
         repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(32, 126)));
      if ($urandom_range(19) == 0)
         line_buf.insert($urandom_range(line_buf.size() - 1), CHAR_NUL);
      if ($urandom_range(24) == 0) begin
         // Fill the store; the next byte of any value ends the line.
         while (line_buf.size() < LINE_BYTES - 1) add_byte(8'($urandom_range(32, 126)));
         add_byte(8'($urandom_range(255)));
      end else begin
         add_byte(CHAR_LF);
      end
      send_buf();
   endtask

   // Raw bytes of any value, sometimes behind a valid prefix; long ones
   // overflow the store.
   task automatic noise_line();
      if ($urandom_range(1)) add_text("Led");
      repeat ($urandom_range(0, 70)) add_byte(8'($urandom_range(255)));
      add_byte(CHAR_LF);
      send_buf();
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      int pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: commands, each value error, the special lines.
      send_line("LedStart");
      send_ticks(30);               // count well up toward the reset reload
      send_line("Led2ms");          // new reload below the count
      send_ticks(45);               // first tick wraps at once, then blinking
      send_line("LedStop");         // LED forced low
      send_line("Led\t+10s");       // largest reload
      send_line("Led +1000ms");
      send_line("Led-5ms");         // minus sign
      send_line("Ledms");           // missing digits
      send_line("Led99999999999ms");// saturating value
      send_line("Led1001ms");
      send_line("Led0ms");
      send_line("Led11s");
      send_line("Led5m");
      send_line("Led7msjunk");      // tail after suffix ignored
      send_line("");                // empty line
      send_line("led5ms");
      add_text("Led5");             // NUL cuts the text before the suffix
      add_byte(CHAR_NUL);
      send_line("ms");
      add_text("LedStart");         // overfull line, last byte dropped
      while (line_buf.size() < LINE_BYTES - 1) add_byte("x");
      add_byte(8'hFF);
      send_buf();
      add_byte(8'h80);
      add_byte(8'h7F);
      send_line("");
      send_line("Led1ms");          // fastest blink for the random part

      // Random: commands, tick bursts, noise. Quiet stretch in the middle.
      while (items_sent < TOTAL_ITEMS) begin
         no_idle = (items_sent >= 500 && items_sent < 800);
         pick = $urandom_range(99);
         if (pick < 55)      random_command();
         else if (pick < 85) send_ticks($urandom_range(1, 30));
         else                noise_line();
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      // Drain: wait for every expected result, then let stray output show up.
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d items: %0d ticks, %0d lines", sb.n_items, sb.n_ticks,
               sb.n_lines);
      $display("lines: %0d ok, %0d invalid value, %0d cmd error; LED toggled %0d times",
               sb.n_ok, sb.n_bad, sb.n_err, sb.n_toggles);
      if (sb.errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("%0d field mismatches", sb.errors);
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ulbc_pkg.sv
hw/rtl/ulbc_ram.sv
hw/rtl/uart_command_led_blink_control.sv
hw/rtl/ulbc_checker.sv
verif/tb_top.sv
